FILE: hdl/scbw_pkg.sv
// shared types and constants for the scroll button to wheel core
`timescale 1ns / 1ps
`default_nettype none
package scbw_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned TimeW = 16;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MASK    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_AXES    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_DIVISOR = 2'd3;

  // axis selector codes
  localparam logic [1:0] AXES_VERT  = 2'd0;
  localparam logic [1:0] AXES_HORIZ = 2'd1;
  localparam logic [1:0] AXES_BOTH  = 2'd2;
  // no axis converted, incoming wheel passes through
  localparam logic [1:0] AXES_NONE  = 2'd3;

  localparam logic [DataW-1:0] RESET_TIMEOUT = 8'd200;
  localparam logic [DataW-1:0] RESET_DIVISOR = 8'd10;

  typedef enum logic [1:0] {
    PHASE_IDLE     = 2'd0,
    PHASE_HELD     = 2'd1,
    PHASE_SCROLLED = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_Y,
    ST_RUN_Y,
    ST_LOAD_X,
    ST_RUN_X,
    ST_CLICK,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] wheel;
    logic [DataW-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/scroll_button_motion_to_wheel_core.sv
// Scroll button emulation: while the configured button is held, motion becomes wheel
// counts through one shared serial divider (per axis a load state, the divider's shift
// steps and a done step) unless no axis is selected. A report goes to its final beat
// directly, after a click beat where one is due, or after the divider runs in scroll mode,
// and waits while the output register stays full. One report is worked on at a time; the
// next is taken once the final beat sits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module scroll_button_motion_to_wheel_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [scbw_pkg::CfgIdxW-1:0]         cfg_index,
  input  wire logic [scbw_pkg::DataW-1:0]           cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [scbw_pkg::DataW-1:0]           buttons_in,
  input  wire logic signed [scbw_pkg::DataW-1:0]    move_x,
  input  wire logic signed [scbw_pkg::DataW-1:0]    move_y,
  input  wire logic signed [scbw_pkg::DataW-1:0]    wheel_v_in,
  input  wire logic signed [scbw_pkg::DataW-1:0]    wheel_h_in,
  input  wire logic [scbw_pkg::TimeW-1:0]           now_ms,
  input  wire logic [scbw_pkg::DataW-1:0]           key_buttons,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [scbw_pkg::DataW-1:0]                buttons_out,
  output logic signed [scbw_pkg::DataW-1:0]         out_x,
  output logic signed [scbw_pkg::DataW-1:0]         out_y,
  output logic signed [scbw_pkg::DataW-1:0]         out_v,
  output logic signed [scbw_pkg::DataW-1:0]         out_h,
  output logic                                      last
);

  localparam int unsigned W = scbw_pkg::DataW;

  // configuration
  logic [W-1:0] scroll_button_mask;
  logic [1:0]   scroll_axes;
  logic [W-1:0] click_timeout_ms;
  logic [W-1:0] motion_divisor;

  // persistent state
  scbw_pkg::phase_t              phase;
  logic [scbw_pkg::TimeW-1:0]    press_start_ms;
  logic [W-1:0]                  remainder_x;
  logic [W-1:0]                  remainder_y;

  // current report
  logic         held;
  logic [W-1:0] fin_btn;
  logic [W-1:0] click_btn;
  logic [W-1:0] fx;
  logic [W-1:0] fy;
  logic [W-1:0] fv;
  logic [W-1:0] fh;
  logic [W-1:0] sum_x;
  logic [W-1:0] sum_y;

  scbw_pkg::state_t state;
  scbw_pkg::state_t state_next;

  logic                 accept;
  logic                 out_free;
  logic                 load_click;
  logic                 load_final;
  logic                 held_now;
  logic                 click_now;
  logic [scbw_pkg::TimeW-1:0] elapsed;
  scbw_pkg::div_req_t   div_req;
  scbw_pkg::div_rsp_t   div_rsp;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign held_now  = (buttons_in & scroll_button_mask) != '0;
  assign elapsed   = now_ms - press_start_ms;
  assign click_now = (phase == scbw_pkg::PHASE_HELD) && (scroll_button_mask != '0) &&
                     (elapsed < {{(scbw_pkg::TimeW-W){1'b0}}, click_timeout_ms});

  scbw_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      scbw_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (held_now) begin
            case (scroll_axes)
              scbw_pkg::AXES_VERT:  state_next = scbw_pkg::ST_LOAD_Y;
              scbw_pkg::AXES_BOTH:  state_next = scbw_pkg::ST_LOAD_Y;
              scbw_pkg::AXES_HORIZ: state_next = scbw_pkg::ST_LOAD_X;
              default:              state_next = scbw_pkg::ST_FINAL;
            endcase
          end else if (click_now) begin
            state_next = scbw_pkg::ST_CLICK;
          end else begin
            state_next = scbw_pkg::ST_FINAL;
          end
        end
      end
      scbw_pkg::ST_LOAD_Y: state_next = scbw_pkg::ST_RUN_Y;
      scbw_pkg::ST_RUN_Y: begin
        if (div_rsp.done) begin
          state_next = (scroll_axes == scbw_pkg::AXES_BOTH) ? scbw_pkg::ST_LOAD_X
                                                             : scbw_pkg::ST_FINAL;
        end
      end
      scbw_pkg::ST_LOAD_X: state_next = scbw_pkg::ST_RUN_X;
      scbw_pkg::ST_RUN_X: begin
        if (div_rsp.done) begin
          state_next = scbw_pkg::ST_FINAL;
        end
      end
      scbw_pkg::ST_CLICK: begin
        if (out_free) begin
          state_next = scbw_pkg::ST_FINAL;
        end
      end
      scbw_pkg::ST_FINAL: begin
        if (out_free) begin
          state_next = scbw_pkg::ST_IDLE;
        end
      end
      default: state_next = scbw_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready         = 1'b0;
    load_click       = 1'b0;
    load_final       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_y;
    div_req.divisor  = motion_divisor;
    case (state)
      scbw_pkg::ST_IDLE:   in_ready = 1'b1;
      scbw_pkg::ST_LOAD_Y: div_req.start = 1'b1;
      scbw_pkg::ST_LOAD_X: begin
        div_req.start    = 1'b1;
        div_req.dividend = sum_x;
      end
      scbw_pkg::ST_CLICK:  load_click = out_free;
      scbw_pkg::ST_FINAL:  load_final = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= scbw_pkg::ST_IDLE;
      scroll_button_mask <= '0;
      scroll_axes        <= scbw_pkg::AXES_VERT;
      click_timeout_ms   <= scbw_pkg::RESET_TIMEOUT;
      motion_divisor     <= scbw_pkg::RESET_DIVISOR;
      phase              <= scbw_pkg::PHASE_IDLE;
      press_start_ms     <= '0;
      remainder_x        <= '0;
      remainder_y        <= '0;
      out_valid          <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          scbw_pkg::REG_MASK:    scroll_button_mask <= cfg_data;
          scbw_pkg::REG_AXES:    scroll_axes        <= cfg_data[1:0];
          scbw_pkg::REG_TIMEOUT: click_timeout_ms   <= cfg_data;
          scbw_pkg::REG_DIVISOR: motion_divisor     <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (held_now) begin
          if (phase == scbw_pkg::PHASE_IDLE) begin
            phase          <= scbw_pkg::PHASE_HELD;
            press_start_ms <= now_ms;
          end
        end else begin
          phase          <= scbw_pkg::PHASE_IDLE;
          press_start_ms <= '0;
        end
      end
      if (state == scbw_pkg::ST_RUN_Y && div_rsp.done) begin
        remainder_y <= div_rsp.rem;
      end
      if (state == scbw_pkg::ST_RUN_X && div_rsp.done) begin
        remainder_x <= div_rsp.rem;
      end
      if (load_final && held && (fv != '0 || fh != '0)) begin
        phase <= scbw_pkg::PHASE_SCROLLED;
      end
      if (load_click || load_final) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // report payload
  always_ff @(posedge clk) begin
    if (accept) begin
      held      <= held_now;
      click_btn <= buttons_in | scroll_button_mask;
      sum_x     <= move_x + remainder_x;
      sum_y     <= move_y + remainder_y;
      if (held_now) begin
        fin_btn <= (buttons_in & ~scroll_button_mask) | key_buttons;
        fx      <= '0;
        fy      <= '0;
        // unconverted axes pass the incoming wheel only when no axis is selected
        fv      <= (scroll_axes == scbw_pkg::AXES_NONE) ? wheel_v_in : '0;
        fh      <= (scroll_axes == scbw_pkg::AXES_NONE) ? wheel_h_in : '0;
      end else begin
        fin_btn <= buttons_in | key_buttons;
        fx      <= click_now ? '0 : move_x;
        fy      <= click_now ? '0 : move_y;
        fv      <= click_now ? '0 : wheel_v_in;
        fh      <= click_now ? '0 : wheel_h_in;
      end
    end else begin
      if (state == scbw_pkg::ST_RUN_Y && div_rsp.done) begin
        fv <= div_rsp.wheel;
      end
      if (state == scbw_pkg::ST_RUN_X && div_rsp.done) begin
        fh <= div_rsp.wheel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_click) begin
      buttons_out <= click_btn;
      out_x       <= '0;
      out_y       <= '0;
      out_v       <= '0;
      out_h       <= '0;
      last        <= 1'b0;
    end else if (load_final) begin
      buttons_out <= fin_btn;
      out_x       <= fx;
      out_y       <= fy;
      out_v       <= fv;
      out_h       <= fh;
      last        <= 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/scbw_div.sv
// serial signed-by-unsigned divider, one quotient bit per cycle, gives negated quotient
`timescale 1ns / 1ps
`default_nettype none
module scbw_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire scbw_pkg::div_req_t req,
  output scbw_pkg::div_rsp_t      rsp
);

  localparam int unsigned W = scbw_pkg::DataW;

  logic               busy;
  logic               done;
  logic [2:0]         count;
  logic               neg;
  logic [W-1:0]       mag;
  logic [W-1:0]       rem;
  logic [W-1:0]       divisor;
  logic [W-1:0]       dividend;
  logic [W:0]         trial;
  logic               fits;
  logic [W-1:0]       rem_next;

  // one restoring step on the magnitude
  always_comb begin
    trial    = {rem, mag[W-1]};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? W'(trial - {1'b0, divisor}) : trial[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !req.start && (count == 3'd7);
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 3'd1;
        if (count == 3'd7) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg      <= req.dividend[W-1];
      mag      <= req.dividend[W-1] ? W'(0) - req.dividend : req.dividend;
      rem      <= '0;
      divisor  <= req.divisor;
      dividend <= req.dividend;
    end else if (busy) begin
      rem <= rem_next;
      mag <= {mag[W-2:0], fits};
    end
  end

  // zero divisor: no count, whole motion stays as remainder
  always_comb begin
    rsp.done = done;
    if (divisor == '0) begin
      rsp.wheel = '0;
      rsp.rem   = dividend;
    end else begin
      rsp.wheel = neg ? mag : W'(0) - mag;
      rsp.rem   = neg ? W'(0) - rem : rem;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/scbw_chk.sv
// port-level checks for the scroll button to wheel core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module scbw_chk (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [scbw_pkg::DataW-1:0]      buttons_out,
  input wire logic signed [scbw_pkg::DataW-1:0] out_x,
  input wire logic signed [scbw_pkg::DataW-1:0] out_y,
  input wire logic signed [scbw_pkg::DataW-1:0] out_v,
  input wire logic signed [scbw_pkg::DataW-1:0] out_h,
  input wire logic                            last
);

  // one report at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a beat");

  // a click beat carries no motion
  a_click_no_motion: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> out_x == '0 && out_y == '0 && out_v == '0 && out_h == '0)
    else $error("click beat with motion");

  // the final beat of a click is still owed, so no new report
  a_click_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken while final beat pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(buttons_out) && $stable(last))
    else $error("output beat changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind scroll_button_motion_to_wheel_core scbw_chk u_scbw_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .buttons_out (buttons_out),
  .out_x       (out_x),
  .out_y       (out_y),
  .out_v       (out_v),
  .out_h       (out_h),
  .last        (last)
);
`default_nettype wire
